/* rtl/core/interval_set_merger_macros.svh */
// Assertion helpers shared by the interval set merger RTL.
`ifndef INTERVAL_SET_MERGER_MACROS_SVH
`define INTERVAL_SET_MERGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("interval set merger check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("interval set merger check failed");

`endif

/* rtl/core/ism_pkg.sv */
package ism_pkg;

    localparam int OUT_VALUE_W = 16;
    localparam int OUT_COUNT_W = 5;
    localparam int STATUS_W    = 3;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_LIST = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXTENDED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_MERGED   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_COVERED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_LIST     = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_LIST
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_COMPARE,
        OP_APPLY,
        OP_ROTATE
    } cell_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t op;
        logic     any_hit;
        logic     merge;
        logic     full;
    } cell_ctrl_t;

    // What a cell reports about the pending add.
    typedef struct packed {
        logic first;
        logic merge;
        logic covered;
    } rpt_flags_t;

endpackage

/* rtl/core/ism_cell.sv */
module ism_cell
    import ism_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   aclk,
    input  cell_ctrl_t             ctrl,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   occupied,
    input  logic                   tail,
    input  logic                   left_lt,
    input  logic                   left_hit,
    input  logic [VALUE_WIDTH-1:0] left_start,
    input  logic [VALUE_WIDTH-1:0] left_end,
    input  logic                   right_hit,
    input  logic [VALUE_WIDTH-1:0] right_start,
    input  logic [VALUE_WIDTH-1:0] right_end,
    input  logic [VALUE_WIDTH-1:0] head_start,
    input  logic [VALUE_WIDTH-1:0] head_end,
    output logic [VALUE_WIDTH-1:0] start_out,
    output logic [VALUE_WIDTH-1:0] end_out,
    output logic                   hit_out,
    output logic                   lt_out,
    output rpt_flags_t             rpt,
    output logic [VALUE_WIDTH-1:0] rpt_start,
    output logic [VALUE_WIDTH-1:0] rpt_end
);

    logic [VALUE_WIDTH-1:0] start_reg, start_next;
    logic [VALUE_WIDTH-1:0] end_reg, end_next;
    logic                   hit_reg, hit_next;
    logic                   lt_reg, lt_next;
    logic                   below_reg, below_next;
    logic                   above_reg, above_next;
    logic [VALUE_WIDTH:0]   value_inc;
    logic [VALUE_WIDTH:0]   end_inc;
    logic                   first;
    logic                   merge_here;

    // Bounds are compared one bit wider so the top value does not wrap.
    assign value_inc  = {1'b0, value} + 1'b1;
    assign end_inc    = {1'b0, end_reg} + 1'b1;
    assign first      = hit_reg && !left_hit;
    assign merge_here = first && right_hit;

    always_comb begin
        hit_next   = hit_reg;
        lt_next    = lt_reg;
        below_next = below_reg;
        above_next = above_reg;
        start_next = start_reg;
        end_next   = end_reg;
        case (ctrl.op)
            OP_COMPARE: begin
                hit_next   = occupied && ({1'b0, start_reg} <= value_inc)
                             && (end_inc >= {1'b0, value});
                lt_next    = occupied && (start_reg < value);
                below_next = value < start_reg;
                above_next = value > end_reg;
            end
            OP_APPLY: begin
                if (ctrl.any_hit) begin
                    if (ctrl.merge) begin
                        // Everything above the merged pair moves down one place.
                        if (!lt_reg) begin
                            start_next = right_start;
                            end_next   = right_end;
                        end else if (first) begin
                            end_next = right_end;
                        end
                    end else if (first) begin
                        if (below_reg) begin
                            start_next = value;
                        end
                        if (above_reg) begin
                            end_next = value;
                        end
                    end
                end else if (!ctrl.full && !lt_reg) begin
                    // Insertion point takes the value, cells above move up one place.
                    if (left_lt) begin
                        start_next = value;
                        end_next   = value;
                    end else begin
                        start_next = left_start;
                        end_next   = left_end;
                    end
                end
            end
            OP_ROTATE: begin
                if (tail) begin
                    start_next = head_start;
                    end_next   = head_end;
                end else begin
                    start_next = right_start;
                    end_next   = right_end;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
        hit_reg   <= hit_next;
        lt_reg    <= lt_next;
        below_reg <= below_next;
        above_reg <= above_next;
    end

    assign start_out   = start_reg;
    assign end_out     = end_reg;
    assign hit_out     = hit_reg;
    assign lt_out      = lt_reg;
    assign rpt.first   = first;
    assign rpt.merge   = merge_here;
    assign rpt.covered = first && !below_reg && !above_reg;
    assign rpt_start   = !first ? '0 : (below_reg ? value : start_reg);
    assign rpt_end     = !first ? '0 :
                         (merge_here ? right_end : (above_reg ? value : end_reg));

endmodule

/* rtl/core/interval_set_merger.sv */
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_command, s_value
// m_        out        m_valid / m_ready    m_status, m_range_start, m_range_end,
//                                           m_interval_count, m_last
//
// For an add request, the accept edge registers the compare flags of every cell;
// once the result register is free, the apply state applies the extend, merge or
// insert shift in the row of cells and loads the result register. A list request
// gives one result per stored interval (one for an empty table), the row
// rotating one place per result. Reset (aresetn low, synchronous) empties the table
// and drops any pending result; interval bounds themselves are not cleared.
// A stalled result holds in the output register and the block waits before it
// produces the next one; a new request is taken only in the idle state.
`include "interval_set_merger_macros.svh"

module interval_set_merger
    import ism_pkg::*;
#(
    parameter int MAX_INTERVALS = 16,
    parameter int VALUE_WIDTH   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [OUT_VALUE_W-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_W-1:0]    m_status,
    output logic [OUT_VALUE_W-1:0] m_range_start,
    output logic [OUT_VALUE_W-1:0] m_range_end,
    output logic [OUT_COUNT_W-1:0] m_interval_count,
    output logic                   m_last
);

    localparam int CW = $clog2(MAX_INTERVALS + 1);

    // Control state.
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     list_idx_reg, list_idx_next;
    logic              m_valid_reg, m_valid_next;

    // Request and result payload.
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [OUT_VALUE_W-1:0] start_reg, start_next;
    logic [OUT_VALUE_W-1:0] end_reg, end_next;
    logic [OUT_COUNT_W-1:0] cnt_reg, cnt_next;
    logic                   last_reg, last_next;

    logic                   accept;
    logic                   out_free;
    logic                   table_full;
    logic                   list_last;
    logic [VALUE_WIDTH-1:0] cell_value;
    cell_ctrl_t             ctrl;

    // Row of cells, padded by one so the top cell sees an empty right neighbor.
    logic [VALUE_WIDTH-1:0] start_arr [MAX_INTERVALS+1];
    logic [VALUE_WIDTH-1:0] end_arr   [MAX_INTERVALS+1];
    logic [MAX_INTERVALS:0] hit_arr;
    logic [MAX_INTERVALS-1:0] lt_arr;
    logic [MAX_INTERVALS-1:0] occupied_arr;
    logic [MAX_INTERVALS-1:0] tail_arr;
    rpt_flags_t             rpt_arr   [MAX_INTERVALS];
    logic [VALUE_WIDTH-1:0] rpt_s_arr [MAX_INTERVALS];
    logic [VALUE_WIDTH-1:0] rpt_e_arr [MAX_INTERVALS];

    // Reduced add report.
    logic [MAX_INTERVALS-1:0] first_vec;
    logic                   any_hit;
    logic                   any_merge;
    logic                   any_covered;
    logic [VALUE_WIDTH-1:0] hit_start;
    logic [VALUE_WIDTH-1:0] hit_end;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign table_full = count_reg == CW'(MAX_INTERVALS);
    assign list_last  = (count_reg == '0) || (list_idx_reg == count_reg - 1'b1);

    // In idle the cells compare straight against the incoming value, so the
    // accept edge already captures every compare flag.
    assign cell_value = (state_reg == ST_IDLE) ? VALUE_WIDTH'(s_value) : value_reg;

    assign start_arr[MAX_INTERVALS] = '0;
    assign end_arr[MAX_INTERVALS]   = '0;
    assign hit_arr[MAX_INTERVALS]   = 1'b0;

    for (genvar j = 0; j < MAX_INTERVALS; j++) begin : g_cell
        logic                   left_lt;
        logic                   left_hit;
        logic [VALUE_WIDTH-1:0] left_start;
        logic [VALUE_WIDTH-1:0] left_end;

        assign occupied_arr[j] = count_reg > CW'(j);
        assign tail_arr[j]     = count_reg == CW'(j + 1);

        if (j == 0) begin : g_head
            // The bottom cell is always the insertion point when nothing lies below.
            assign left_lt    = 1'b1;
            assign left_hit   = 1'b0;
            assign left_start = '0;
            assign left_end   = '0;
        end else begin : g_body
            assign left_lt    = lt_arr[j-1];
            assign left_hit   = hit_arr[j-1];
            assign left_start = start_arr[j-1];
            assign left_end   = end_arr[j-1];
        end

        ism_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .value       (cell_value),
            .occupied    (occupied_arr[j]),
            .tail        (tail_arr[j]),
            .left_lt     (left_lt),
            .left_hit    (left_hit),
            .left_start  (left_start),
            .left_end    (left_end),
            .right_hit   (hit_arr[j+1]),
            .right_start (start_arr[j+1]),
            .right_end   (end_arr[j+1]),
            .head_start  (start_arr[0]),
            .head_end    (end_arr[0]),
            .start_out   (start_arr[j]),
            .end_out     (end_arr[j]),
            .hit_out     (hit_arr[j]),
            .lt_out      (lt_arr[j]),
            .rpt         (rpt_arr[j]),
            .rpt_start   (rpt_s_arr[j]),
            .rpt_end     (rpt_e_arr[j])
        );
    end

    // At most one cell is the first hit, so its report is picked by an OR over the row.
    always_comb begin
        any_hit     = 1'b0;
        any_merge   = 1'b0;
        any_covered = 1'b0;
        hit_start   = '0;
        hit_end     = '0;
        first_vec   = '0;
        for (int j = 0; j < MAX_INTERVALS; j++) begin
            first_vec[j] = rpt_arr[j].first;
            any_hit      = any_hit | rpt_arr[j].first;
            any_merge    = any_merge | rpt_arr[j].merge;
            any_covered  = any_covered | rpt_arr[j].covered;
            hit_start    = hit_start | rpt_s_arr[j];
            hit_end      = hit_end | rpt_e_arr[j];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_command == CMD_LIST) ? ST_LIST : ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (out_free && list_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: cell commands, table count and result register.
    always_comb begin
        s_ready       = 1'b0;
        ctrl.op       = OP_HOLD;
        ctrl.any_hit  = any_hit;
        ctrl.merge    = any_merge;
        ctrl.full     = table_full;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        value_next    = value_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        status_next   = status_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                ctrl.op       = OP_COMPARE;
                list_idx_next = '0;
                if (accept) begin
                    value_next = cell_value;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    ctrl.op = OP_APPLY;
                    if (any_hit) begin
                        if (any_merge) begin
                            count_next  = count_reg - 1'b1;
                            status_next = STATUS_MERGED;
                        end else if (any_covered) begin
                            status_next = STATUS_COVERED;
                        end else begin
                            status_next = STATUS_EXTENDED;
                        end
                        start_next = OUT_VALUE_W'(hit_start);
                        end_next   = OUT_VALUE_W'(hit_end);
                    end else begin
                        if (table_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            count_next  = count_reg + 1'b1;
                            status_next = STATUS_NEW;
                        end
                        start_next = OUT_VALUE_W'(value_reg);
                        end_next   = OUT_VALUE_W'(value_reg);
                    end
                    m_valid_next = 1'b1;
                    cnt_next     = OUT_COUNT_W'(count_next);
                    last_next    = 1'b1;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    status_next   = STATUS_LIST;
                    cnt_next      = OUT_COUNT_W'(count_reg);
                    last_next     = list_last;
                    list_idx_next = list_idx_reg + 1'b1;
                    if (count_reg == '0) begin
                        start_next = '0;
                        end_next   = '0;
                    end else begin
                        // The bottom cell is reported and the row turns one place.
                        ctrl.op    = OP_ROTATE;
                        start_next = OUT_VALUE_W'(start_arr[0]);
                        end_next   = OUT_VALUE_W'(end_arr[0]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        status_reg <= status_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_range_start    = start_reg;
    assign m_range_end      = end_reg;
    assign m_interval_count = cnt_reg;
    assign m_last           = last_reg;

    // The table never holds more intervals than it has cells.
    `ISM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_INTERVALS))
    // Intervals stay disjoint, so a value has at most one first matching cell.
    `ISM_ASSERT_NOW(a_first_unique, aclk, aresetn, state_reg == ST_APPLY, $onehot0(first_vec))
    // A merge can only come from a matching cell and never from a covered value.
    `ISM_ASSERT_NOW(a_merge_hit, aclk, aresetn, state_reg == ST_APPLY && any_merge,
        $onehot(first_vec) && !any_covered)
    // An accepted add puts the controller in the apply state in the next cycle.
    `ISM_ASSERT_NEXT(a_add_apply, aclk, aresetn, accept && s_command == CMD_ADD,
        state_reg == ST_APPLY)

endmodule
